FILE: design/lkc_pkg.sv
`default_nettype none
package lkc_pkg;

	localparam int KEY_W = 64;
	localparam int CAP_W = 9;
	localparam int OCC_W = 9;
	localparam int OUT_TDATA_W = 16;
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	typedef struct packed {
		logic start;
		logic step;
		logic wr;
		logic fin_hit;
		logic fin_miss;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic eq;
		logic last;
		logic empty;
		logic room;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

FILE: design/lkc_ctrl.sv
`default_nettype none
module lkc_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_axis_tvalid,
	output logic             s_axis_tready,
	input  lkc_pkg::sts_t    sts,
	output lkc_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_INSERT = 2'd2;
	localparam logic [1:0] ST_POST   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.start = 1'b1;
					state_d = sts.empty ? ST_INSERT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.wr = 1'b1;
				if (sts.eq) begin
					cmd.fin_hit = 1'b1;
					state_d = ST_POST;
				end else begin
					cmd.step = 1'b1;
					if (sts.last) begin
						state_d = ST_INSERT;
					end
				end
			end
			ST_INSERT: begin
				cmd.fin_miss = 1'b1;
				cmd.wr = sts.room;
				state_d = ST_POST;
			end
			ST_POST: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: design/lkc_datapath.sv
`default_nettype none
module lkc_datapath #(
	parameter int DEPTH = 256
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire [lkc_pkg::KEY_W-1:0]             s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	output logic [lkc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	input  wire                                  cfg_valid,
	input  wire [lkc_pkg::CAP_W-1:0]             cfg_data,
	input  lkc_pkg::cmd_t                        cmd,
	output lkc_pkg::sts_t                        sts
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > lkc_pkg::CAP_W) ? CW : lkc_pkg::CAP_W;
	localparam int PADW = lkc_pkg::OUT_TDATA_W - lkc_pkg::OCC_W - 2;

	logic [lkc_pkg::KEY_W-1:0] mem [DEPTH];
	logic [lkc_pkg::KEY_W-1:0] rd_q;
	logic [lkc_pkg::KEY_W-1:0] key_q;
	logic [lkc_pkg::KEY_W-1:0] carry_q;
	logic [IW-1:0]             idx_q;
	logic [IW-1:0]             rd_addr;
	logic [CW-1:0]             count_q;
	logic [lkc_pkg::CAP_W-1:0] cap_q;
	logic [lkc_pkg::CAP_W-1:0] cap_nz;
	logic [MW-1:0]             cap_ext;
	logic [MW-1:0]             cap_eff_m;
	logic [CW-1:0]             cap_eff;
	logic [MW-1:0]             count_ext;
	logic                      res_hit_q;
	logic                      res_disp_q;
	logic                      out_hit_q;
	logic                      out_disp_q;
	logic [lkc_pkg::OCC_W-1:0] out_occ_q;

	// effective capacity, clamped to one..DEPTH
	assign cap_nz = (cap_q == '0) ? lkc_pkg::CAP_W'(1) : cap_q;
	assign cap_ext = MW'(cap_nz);
	assign cap_eff_m = (cap_ext > MW'(DEPTH)) ? MW'(DEPTH) : cap_ext;
	assign cap_eff = cap_eff_m[CW-1:0];
	assign count_ext = MW'(count_q);

	assign rd_addr = cmd.start ? '0 : (idx_q + IW'(1));

	assign sts.eq = (rd_q == key_q);
	assign sts.last = ((CW'(idx_q) + CW'(1)) == count_q);
	assign sts.empty = (count_q == '0);
	assign sts.room = (count_q < cap_eff);
	assign sts.out_free = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[idx_q] <= carry_q;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= s_axis_tdata;
			carry_q <= s_axis_tdata;
			idx_q <= '0;
		end else if (cmd.step) begin
			carry_q <= rd_q;
			idx_q <= idx_q + IW'(1);
		end
		if (cmd.fin_hit) begin
			res_hit_q <= 1'b1;
			res_disp_q <= 1'b0;
		end else if (cmd.fin_miss) begin
			res_hit_q <= 1'b0;
			res_disp_q <= !sts.room;
		end
		if (cmd.load_out) begin
			out_hit_q <= res_hit_q;
			out_disp_q <= res_disp_q;
			out_occ_q <= count_ext[lkc_pkg::OCC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q <= lkc_pkg::CAP_RESET;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.fin_miss) begin
				count_q <= sts.room ? (count_q + CW'(1)) : cap_eff;
			end
			if (cmd.load_out) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// tdata from bit 0: hit, displaced, occupancy, zero pad
	assign m_axis_tdata = {{PADW{1'b0}}, out_occ_q, out_disp_q, out_hit_q};

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");
	a_miss_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_miss && sts.room |=> count_q == $past(count_q) + CW'(1))
		else $error("miss with room did not grow the count");
	a_hit_keep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_hit |=> count_q == $past(count_q))
		else $error("hit changed the count");
	a_hit_no_disp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(out_hit_q && out_disp_q))
		else $error("displacement reported on a hit");
`endif

endmodule
`default_nettype wire

FILE: design/lru_key_cache.sv
`default_nettype none
// Fully associative LRU store of 64-bit keys, one result word per key word. Keys live in a
// memory with one read and one write port, ordered from most to least recent; each lookup
// walks it one entry per cycle while shifting entries down behind it. A hit ends the walk
// at its position and a miss walks all held keys, one key at a time, before inserting. The
// next key is accepted only after the result word is loaded, which can wait on m_axis_tready.
// The memory read, one entry per cycle, sets the pace of the walk. Capacity writes on
// cfg are taken at any time but are meant for idle periods; zero acts as one and values above
// DEPTH act as DEPTH.
module lru_key_cache #(
	parameter int DEPTH = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [63:0] s_axis_tdata,   // key
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // hit, displaced, occupancy[8:0], zero pad
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [8:0]  cfg_data        // capacity
);

	lkc_pkg::cmd_t cmd;
	lkc_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	lkc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	lkc_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule
`default_nettype wire

FILE: sim/lru_monitor.sv
`default_nettype none
module lru_monitor #(
	parameter int DEPTH = 256
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       s_axis_tvalid,
	input  wire                       s_axis_tready,
	input  wire  [63:0]               s_axis_tdata,   // key
	input  wire                       m_axis_tvalid,
	input  wire                       m_axis_tready,
	input  wire  [15:0]               m_axis_tdata,   // hit, displaced, occupancy[8:0], zero pad
	input  wire                       cfg_valid,
	input  wire                       cfg_ready,
	input  wire  [lkc_pkg::CAP_W-1:0] cfg_data,       // capacity
	output int                        mismatch_count,
	output int                        results_due
);

	typedef struct packed {
		logic [lkc_pkg::OCC_W-1:0] occupancy;
		logic                      displaced;
		logic                      hit;
	} lookup_result_t;

	logic [lkc_pkg::KEY_W-1:0] recency [DEPTH];
	int unsigned               held;
	logic [lkc_pkg::CAP_W-1:0] capacity;
	lookup_result_t            expected_q[$];

	function automatic int unsigned usable_capacity(input logic [lkc_pkg::CAP_W-1:0] cap);
		if (cap == '0)
			return 1;
		if (cap > DEPTH)
			return DEPTH;
		return cap;
	endfunction

	// search, then move or insert the key at the most recent end
	task automatic lookup_key(input logic [lkc_pkg::KEY_W-1:0] key, output lookup_result_t res);
		int unsigned n;
		int unsigned pos;
		int unsigned lim;
		logic        found;
		n = held;
		lim = usable_capacity(capacity);
		pos = 0;
		found = 1'b0;
		res = '0;
		while (pos < n && !found) begin
			if (recency[pos] == key)
				found = 1'b1;
			else
				pos++;
		end
		res.hit = found;
		if (!found) begin
			if (n >= lim) begin
				n = lim - 1;
				res.displaced = 1'b1;
			end
			pos = n;
			n++;
		end
		for (int i = pos; i > 0; i--)
			recency[i] = recency[i-1];
		recency[0] = key;
		held = n;
		res.occupancy = n[lkc_pkg::OCC_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		lookup_result_t got;
		lookup_result_t want;
		if (!arst_n) begin
			held = 0;
			capacity = lkc_pkg::CAP_RESET;
			expected_q.delete();
			mismatch_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = lookup_result_t'(m_axis_tdata[$bits(lookup_result_t)-1:0]);
				if (expected_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result word hit=%0b displaced=%0b occupancy=%0d",
							$realtime, got.hit, got.displaced, got.occupancy);
				end else begin
					want = expected_q[0];
					expected_q.delete(0);
					if (got.hit !== want.hit || got.displaced !== want.displaced ||
							got.occupancy !== want.occupancy) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: expected hit=%0b disp=%0b occ=%0d, got hit=%0b disp=%0b occ=%0d",
								$realtime, want.hit, want.displaced, want.occupancy,
								got.hit, got.displaced, got.occupancy);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				capacity = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				lookup_key(s_axis_tdata, want);
				expected_q.insert(expected_q.size(), want);
			end
		end
		results_due = expected_q.size();
	end

endmodule
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
module tb;

	localparam int DEPTH = 256;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE = DEPTH + 8;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	logic [lkc_pkg::KEY_W-1:0] s_axis_tdata;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready;
	logic [15:0]               m_axis_tdata;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [lkc_pkg::CAP_W-1:0] cfg_data;
	int                        mismatch_count;
	int                        results_due;
	int                        hold_asks;
	int                        holds_done;
	int                        idle_cycles;
	logic [lkc_pkg::KEY_W-1:0] key_pool [512];

	always #5 clk = ~clk;

	lru_key_cache #(.DEPTH(DEPTH)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	lru_monitor #(.DEPTH(DEPTH)) monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// receiver: stretches of always ready, random, sparse and mostly ready, long hold-off on request
	initial begin : receiver
		int         mode;
		int         span;
		logic [2:0] beat;
		m_axis_tready = 1'b0;
		holds_done = 0;
		beat = '0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 120);
			repeat (span) begin
				@(negedge clk);
				beat++;
				if (hold_asks != holds_done) begin
					m_axis_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					holds_done++;
				end else begin
					case (mode)
						0: m_axis_tready <= 1'b1;
						1: m_axis_tready <= ($urandom_range(0, 1) == 1);
						2: m_axis_tready <= ($urandom_range(0, 3) == 0);
						default: m_axis_tready <= (beat != '0);
					endcase
				end
			end
		end
	end

	task automatic send_key(input logic [lkc_pkg::KEY_W-1:0] key);
		s_axis_tdata <= key;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (results_due != 0);
	endtask

	task automatic write_capacity(input logic [lkc_pkg::CAP_W-1:0] value);
		wait_drained();
		repeat (SETTLE) @(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [lkc_pkg::CAP_W-1:0] cap, input int count,
			input int pool_size, input bit with_hold, input bit with_drain);
		int                        burst;
		int                        gap;
		logic [lkc_pkg::KEY_W-1:0] key;
		write_capacity(cap);
		for (int i = 0; i < pool_size; i++)
			key_pool[i] = {$urandom, $urandom};
		burst = 0;
		for (int k = 0; k < count; k++) begin
			if (burst == 0) begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					s_axis_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst = $urandom_range(1, 24);
			end
			if (with_hold && k == count / 3)
				hold_asks++;
			if (with_drain && k == 2 * count / 3)
				wait_drained();
			if ($urandom_range(0, 9) == 0)
				key = {$urandom, $urandom};
			else
				key = key_pool[$urandom_range(0, pool_size - 1)];
			send_key(key);
			burst--;
		end
	endtask

	initial begin : stimulus
		logic [lkc_pkg::CAP_W-1:0] c;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_asks = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// extremes of the key, hits at several depths
		send_key(64'h0);
		send_key(64'hFFFF_FFFF_FFFF_FFFF);
		send_key(64'h0);
		send_key(64'hFFFF_FFFF_FFFF_FFFF);
		send_key(64'h1);
		send_key(64'h8000_0000_0000_0000);
		send_key(64'hAAAA_AAAA_AAAA_AAAA);
		send_key(64'h5555_5555_5555_5555);
		send_key(64'h0);
		send_key(64'h1);

		// capacity dropped below occupancy: hit keeps all, next miss trims
		write_capacity(9'd2);
		send_key(64'h5555_5555_5555_5555);
		send_key(64'h1234);
		send_key(64'h5555_5555_5555_5555);
		send_key(64'h0);

		// zero capacity acts as one
		write_capacity(9'd0);
		send_key(64'h0);
		send_key(64'h77);
		send_key(64'h77);
		send_key(64'h78);

		// oversized capacity saturates
		write_capacity(9'd511);
		send_key(64'h79);
		send_key(64'h7A);
		send_key(64'h78);

		run_phase(9'd256, 450, 280, 1'b1, 1'b1);
		c = lkc_pkg::CAP_W'($urandom_range(2, 8));
		run_phase(c, 90, int'(c) + int'($urandom_range(1, 4)), 1'b0, 1'b0);
		run_phase(9'd1, 90, 3, 1'b1, 1'b0);
		run_phase(9'd0, 90, 2, 1'b0, 1'b1);
		c = lkc_pkg::CAP_W'($urandom_range(9, 40));
		run_phase(c, 90, int'(c) + int'($urandom_range(0, int'(c) / 2 + 2)), 1'b0, 1'b0);
		run_phase(9'd3, 90, 5, 1'b0, 1'b0);
		c = lkc_pkg::CAP_W'($urandom_range(300, 511));
		run_phase(c, 90, 24, 1'b0, 1'b0);

		wait_drained();
		repeat (SETTLE) @(negedge clk);
		if (mismatch_count == 0 && results_due == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
